>>> hdl/ihe_pkg.sv
// shared widths, register indexes and types of the image histogram engine
package ihe_pkg;

    localparam int PIX_W      = 16;
    localparam int IDX_W      = 6;
    localparam int TOT_W      = 24;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_PAD_W  = OUT_DATA_W - (IDX_W + TOT_W + TOT_W + PIX_W + IDX_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int BINS_CFG_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS       = 2'd2;

    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    typedef struct packed {
        logic vld;
        logic cnt;
        logic last;
    } t_pix_tag;

endpackage

>>> hdl/ihe_bin_ram.sv
// bin count memory, one write and one registered read port, valid bit per entry
module ihe_bin_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    input  logic          i_clear,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DW-1:0]    r_rdata;
    logic [DEPTH-1:0] r_valid;
    logic             r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_ok <= r_valid[i_raddr];
            end
        end
    end

    // never written since reset or last dump reads as zero
    assign o_rdata = r_rd_ok ? r_rdata : '0;

endmodule

>>> hdl/ihe_bin_div.sv
// range check, scaling multiply and pipelined restoring divider for the bin number
module ihe_bin_div #(
    parameter int QW = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic [ihe_pkg::PIX_W-1:0] i_pixel,
    input  logic                    i_last,
    input  logic [ihe_pkg::PIX_W-1:0] i_low,
    input  logic [ihe_pkg::PIX_W-1:0] i_high,
    input  logic [QW-1:0]           i_bins,
    output logic [QW-1:0]           o_quot,
    output logic                    o_zero,
    output ihe_pkg::t_pix_tag       o_tag
);

    localparam int NUM_W = ihe_pkg::PIX_W + QW;

    ihe_pkg::t_pix_tag         r_tag  [QW+1];
    logic [NUM_W-1:0]          r_rem  [QW+1];
    logic [QW-1:0]             r_quot [QW+1];
    logic                      r_zero [QW+1];

    logic [ihe_pkg::PIX_W-1:0] w_span;
    logic [ihe_pkg::PIX_W-1:0] w_diff;
    logic                      w_in_range;

    assign w_span     = i_high - i_low;
    assign w_diff     = i_pixel - i_low;
    assign w_in_range = (i_low <= i_high) && (i_pixel >= i_low) && (i_pixel <= i_high);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else begin
            r_tag[0].vld  <= i_vld;
            r_tag[0].cnt  <= i_vld && w_in_range;
            r_tag[0].last <= i_vld && i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= NUM_W'(w_diff * i_bins);
        r_quot[0] <= '0;
        r_zero[0] <= (w_span == '0);
    end

    for (genvar s = 1; s <= QW; s++) begin : g_stage
        localparam int J = QW - s;
        logic [NUM_W-1:0] w_trial;
        logic             w_ge;

        assign w_trial = NUM_W'(w_span) << J;
        assign w_ge    = (r_rem[s-1] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[s] <= '0;
            end else begin
                r_tag[s] <= r_tag[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= w_ge ? (r_rem[s-1] - w_trial) : r_rem[s-1];
            r_quot[s] <= r_quot[s-1] | (QW'(w_ge) << J);
            r_zero[s] <= r_zero[s-1];
        end
    end

    assign o_quot = r_quot[QW];
    assign o_zero = r_zero[QW];
    assign o_tag  = r_tag[QW];

endmodule

>>> hdl/ihe_mode_div.sv
// multiply and bit-serial divide for the pixel value of the mode bin
module ihe_mode_div #(
    parameter int BIN_W = 6,
    parameter int DEN_W = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ihe_pkg::PIX_W-1:0] i_span,
    input  logic [BIN_W-1:0]          i_mode_bin,
    input  logic [DEN_W-1:0]          i_bins,
    output logic                      o_done,
    output logic [ihe_pkg::PIX_W-1:0] o_quot
);

    localparam int NUM_W = ihe_pkg::PIX_W + BIN_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_rem_sh;
    logic             w_ge;
    logic [DEN_W:0]   w_rem_sub;

    assign w_rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, i_bins});
    assign w_rem_sub = w_rem_sh - {1'b0, i_bins};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= NUM_W'(i_span * i_mode_bin);
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= r_num << 1;
            r_rem  <= w_ge ? w_rem_sub[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot[ihe_pkg::PIX_W-1:0];

endmodule

>>> hdl/image_histogram_engine.sv
// image histogram engine top level: bin update pipeline and dump sequencer
//
//  channel   dir  handshake                     contents
//  s_axis    in   i_s_axis_tvalid/o_..._tready  tdata pixel, tlast last
//  m_axis    out  o_m_axis_tvalid/i_..._tready  tdata bin result, tlast final_res
//  cfg       in   i_cfg_we                      i_cfg_idx, i_cfg_data
//
//  pixels: one transfer per cycle; a count is written back through the range register, the
//  divider stages and the write register; the read-modify-write of the bin memory forwards
//  the previous write. dump after a last pixel: one memory read per bin for the mode
//  search, then the mode value divider, then one result per cycle while the receiver is
//  ready, out of the memory read port; no pixel is taken from the last pixel to the final
//  result. reset clears the per-entry valid bits at once, so no clearing pass runs.
module image_histogram_engine #(
    parameter int MAX_BINS    = 64,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [ihe_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,  // pixel
    input  logic                               i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // bin_index, bin_total, cumulative_total, mode_value, mode_bin, zero pad
    output logic [ihe_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic                               o_m_axis_tlast,
    input  logic                               i_cfg_we,
    input  logic [ihe_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ihe_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int BIN_W  = $clog2(MAX_BINS);
    localparam int CNTB_W = $clog2(MAX_BINS + 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_SCAN,
        ST_MODE,
        ST_EMIT
    } t_state;

    function automatic logic [ihe_pkg::TOT_W-1:0] f_clip(input logic [COUNT_WIDTH-1:0] v);
        logic [32:0] e;
        e = 33'(v);
        f_clip = (e > 33'(ihe_pkg::TOT_MAX)) ? ihe_pkg::TOT_MAX : e[ihe_pkg::TOT_W-1:0];
    endfunction

    // configuration
    logic [ihe_pkg::PIX_W-1:0]      r_low;
    logic [ihe_pkg::PIX_W-1:0]      r_high;
    logic [ihe_pkg::BINS_CFG_W-1:0] r_bins_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low      <= '0;
            r_high     <= '1;
            r_bins_cfg <= ihe_pkg::BINS_CFG_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ihe_pkg::CFG_RANGE_LOW:  r_low      <= i_cfg_data;
                ihe_pkg::CFG_RANGE_HIGH: r_high     <= i_cfg_data;
                ihe_pkg::CFG_BINS:       r_bins_cfg <= i_cfg_data[ihe_pkg::BINS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CNTB_W-1:0] w_bins;
    logic [BIN_W-1:0]  w_last_bin;

    always_comb begin
        if (r_bins_cfg == '0) begin
            w_bins = CNTB_W'(1);
        end else if (r_bins_cfg > ihe_pkg::BINS_CFG_W'(MAX_BINS)) begin
            w_bins = CNTB_W'(MAX_BINS);
        end else begin
            w_bins = CNTB_W'(r_bins_cfg);
        end
    end

    assign w_last_bin = BIN_W'(w_bins - CNTB_W'(1));

    // state
    t_state                    r_state;
    logic                      r_last_pend;
    logic [BIN_W-1:0]          r_k;
    logic                      r_sc_rd;
    logic                      r_sc_dv;
    logic [BIN_W-1:0]          r_sc_idx;
    logic [COUNT_WIDTH-1:0]    r_best;
    logic [BIN_W-1:0]          r_mode_bin;
    logic [ihe_pkg::PIX_W-1:0] r_mode_val;
    logic [BIN_W-1:0]          r_em_idx;
    logic [COUNT_WIDTH-1:0]    r_cum;
    logic                      r_out_vld;
    logic                      r_out_last;
    logic [ihe_pkg::OUT_DATA_W-1:0] r_out_data;

    // input side and bin number pipeline
    logic                      w_in_acc;
    logic [CNTB_W-1:0]         w_quot;
    logic                      w_zero;
    ihe_pkg::t_pix_tag         w_tag;
    logic [BIN_W-1:0]          w_bin_addr;

    assign o_s_axis_tready = (r_state == ST_ACCUM) && !r_last_pend;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    ihe_bin_div #(
        .QW (CNTB_W)
    ) u_bin_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_in_acc),
        .i_pixel (i_s_axis_tdata[ihe_pkg::PIX_W-1:0]),
        .i_last  (i_s_axis_tlast),
        .i_low   (r_low),
        .i_high  (r_high),
        .i_bins  (w_bins),
        .o_quot  (w_quot),
        .o_zero  (w_zero),
        .o_tag   (w_tag)
    );

    always_comb begin
        if (w_zero) begin
            w_bin_addr = '0;
        end else if (w_quot >= w_bins) begin
            w_bin_addr = w_last_bin;
        end else begin
            w_bin_addr = BIN_W'(w_quot);
        end
    end

    // read-modify-write of bin counts
    logic                   r_w_cnt;
    logic                   r_w_last;
    logic [BIN_W-1:0]       r_w_addr;
    logic                   r_fw_vld;
    logic [BIN_W-1:0]       r_fw_addr;
    logic [COUNT_WIDTH-1:0] r_fw_data;
    logic [COUNT_WIDTH-1:0] w_rdata;
    logic [COUNT_WIDTH-1:0] w_base;
    logic                   w_wr_en;
    logic [COUNT_WIDTH-1:0] w_wr_data;

    assign w_base    = (r_fw_vld && (r_fw_addr == r_w_addr)) ? r_fw_data : w_rdata;
    assign w_wr_en   = r_w_cnt;
    assign w_wr_data = (w_base == CNT_MAX) ? w_base : (w_base + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_cnt  <= 1'b0;
            r_w_last <= 1'b0;
            r_fw_vld <= 1'b0;
        end else begin
            r_w_cnt  <= w_tag.vld && w_tag.cnt;
            r_w_last <= w_tag.vld && w_tag.last;
            r_fw_vld <= w_wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w_addr  <= w_bin_addr;
        r_fw_addr <= r_w_addr;
        r_fw_data <= w_wr_data;
    end

    // dump sequencing
    logic                      w_out_free;
    logic                      w_emit_final;
    logic                      w_out_load;
    logic                      w_sc_better;
    logic [BIN_W-1:0]          w_mode_nxt;
    logic                      w_sc_end;
    logic                      w_md_done;
    logic [ihe_pkg::PIX_W-1:0] w_md_quot;
    logic [COUNT_WIDTH:0]      w_cum_sum;
    logic [COUNT_WIDTH-1:0]    w_cum;
    logic                      w_rd_en;
    logic [BIN_W-1:0]          w_rd_addr;
    logic                      w_clear;

    assign w_out_free   = !r_out_vld || i_m_axis_tready;
    assign w_emit_final = (r_em_idx == w_last_bin);
    assign w_out_load   = (r_state == ST_EMIT) && w_out_free;
    assign w_sc_better  = r_sc_dv && (w_rdata > r_best);
    assign w_mode_nxt   = w_sc_better ? r_sc_idx : r_mode_bin;
    assign w_sc_end     = (r_state == ST_SCAN) && r_sc_dv && (r_sc_idx == w_last_bin);
    assign w_cum_sum    = (COUNT_WIDTH + 1)'(r_cum) + (COUNT_WIDTH + 1)'(w_rdata);
    assign w_cum        = w_cum_sum[COUNT_WIDTH] ? CNT_MAX : w_cum_sum[COUNT_WIDTH-1:0];
    assign w_clear      = w_out_load && w_emit_final;

    always_comb begin
        case (r_state)
            ST_ACCUM: begin
                w_rd_en   = w_tag.vld && w_tag.cnt;
                w_rd_addr = w_bin_addr;
            end
            ST_SCAN: begin
                w_rd_en   = r_sc_rd;
                w_rd_addr = r_k;
            end
            ST_MODE: begin
                w_rd_en   = w_md_done;
                w_rd_addr = '0;
            end
            ST_EMIT: begin
                w_rd_en   = w_out_load && !w_emit_final;
                w_rd_addr = r_em_idx + 1'b1;
            end
            default: begin
                w_rd_en   = 1'b0;
                w_rd_addr = '0;
            end
        endcase
    end

    ihe_bin_ram #(
        .DEPTH (MAX_BINS),
        .AW    (BIN_W),
        .DW    (COUNT_WIDTH)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_wr_en),
        .i_waddr (r_w_addr),
        .i_wdata (w_wr_data),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .i_clear (w_clear),
        .o_rdata (w_rdata)
    );

    ihe_mode_div #(
        .BIN_W (BIN_W),
        .DEN_W (CNTB_W)
    ) u_mode_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sc_end),
        .i_span     (r_high - r_low),
        .i_mode_bin (w_mode_nxt),
        .i_bins     (w_bins),
        .o_done     (w_md_done),
        .o_quot     (w_md_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCUM;
            r_last_pend <= 1'b0;
            r_k         <= '0;
            r_sc_rd     <= 1'b0;
            r_sc_dv     <= 1'b0;
            r_sc_idx    <= '0;
            r_best      <= '0;
            r_mode_bin  <= '0;
            r_mode_val  <= '0;
            r_em_idx    <= '0;
            r_cum       <= '0;
            r_out_vld   <= 1'b0;
            r_out_last  <= 1'b0;
            r_out_data  <= '0;
        end else begin
            if (r_out_vld && i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_ACCUM: begin
                    if (w_in_acc && i_s_axis_tlast) begin
                        r_last_pend <= 1'b1;
                    end
                    if (r_w_last) begin
                        r_state    <= ST_SCAN;
                        r_k        <= '0;
                        r_sc_rd    <= 1'b1;
                        r_sc_dv    <= 1'b0;
                        r_best     <= '0;
                        r_mode_bin <= '0;
                    end
                end
                ST_SCAN: begin
                    r_sc_dv  <= r_sc_rd;
                    r_sc_idx <= r_k;
                    if (r_sc_rd) begin
                        if (r_k == w_last_bin) begin
                            r_sc_rd <= 1'b0;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                    if (w_sc_better) begin
                        r_best     <= w_rdata;
                        r_mode_bin <= r_sc_idx;
                    end
                    if (w_sc_end) begin
                        r_state <= ST_MODE;
                    end
                end
                ST_MODE: begin
                    if (w_md_done) begin
                        r_mode_val <= (r_high > r_low) ? (r_low + w_md_quot) : r_low;
                        r_em_idx   <= '0;
                        r_cum      <= '0;
                        r_state    <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_out_load) begin
                        r_out_vld  <= 1'b1;
                        r_out_last <= w_emit_final;
                        r_out_data <= {
                            ihe_pkg::OUT_PAD_W'(0),
                            w_emit_final ? ihe_pkg::IDX_W'(r_mode_bin) : ihe_pkg::IDX_W'(0),
                            w_emit_final ? r_mode_val : ihe_pkg::PIX_W'(0),
                            f_clip(w_cum),
                            f_clip(w_rdata),
                            ihe_pkg::IDX_W'(r_em_idx)
                        };
                        r_cum <= w_cum;
                        if (w_emit_final) begin
                            r_state     <= ST_ACCUM;
                            r_last_pend <= 1'b0;
                        end else begin
                            r_em_idx <= r_em_idx + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_ACCUM;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // no count update while the dump owns the memory
    a_no_write_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_ACCUM) |-> !w_wr_en)
        else $error("bin write during dump");

    // final result hands the block back to pixel intake
    a_final_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && w_emit_final) |=> (r_state == ST_ACCUM) && !r_last_pend
            && o_m_axis_tlast)
        else $error("final result did not reopen input");

    // mode search stays within bins in use
    a_mode_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MODE) |-> (r_mode_bin <= w_last_bin))
        else $error("mode bin beyond bins in use");

    // no pixel taken while a dump is pending
    a_no_intake_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_pend |-> !w_in_acc)
        else $error("pixel transfer after last pixel");
`endif

endmodule

>>> test/image_histogram_engine_test.sv
// self-checking testbench of the image histogram engine: pixel streams against a bin count model
module image_histogram_engine_test;

    localparam int MODEL_BINS = 64;
    localparam int SETTLE     = 64;
    localparam int LIMIT      = 2000000;
    localparam int CALM_AFTER = 230;
    localparam int ITEM_GOAL  = 270;

    localparam logic [ihe_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [ihe_pkg::PIX_W-1:0] value;
        logic                      closing;
    } t_pixel;

    typedef struct packed {
        logic [ihe_pkg::IDX_W-1:0] slot;
        logic [ihe_pkg::TOT_W-1:0] count;
        logic [ihe_pkg::TOT_W-1:0] running;
        logic [ihe_pkg::PIX_W-1:0] peak_value;
        logic [ihe_pkg::IDX_W-1:0] peak_slot;
        logic                      closing;
    } t_bin_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [ihe_pkg::IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                           i_s_axis_tlast = 1'b0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic [ihe_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                           o_m_axis_tlast;
    logic                           i_cfg_we = 1'b0;
    logic [ihe_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [ihe_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // register copies and bin counts of the model
    logic [ihe_pkg::PIX_W-1:0]      span_low = 16'd0;
    logic [ihe_pkg::PIX_W-1:0]      span_high = 16'hFFFF;
    logic [ihe_pkg::BINS_CFG_W-1:0] bin_setting = 7'd64;
    logic [ihe_pkg::TOT_W-1:0]      tally [MODEL_BINS] = '{default: '0};

    t_pixel      pixel_feed [$];
    t_bin_result bins_due [$];
    t_bin_result want;

    int pushed = 0;
    int accepted = 0;
    int failed = 0;
    int cycles = 0;
    int feed_gap = 0;
    int sink_gap = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    logic calm = 1'b0;

    image_histogram_engine uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    task automatic tally_pixel(input logic [ihe_pkg::PIX_W-1:0] px, input logic tail);
        int unsigned span_bins;
        int unsigned span;
        int unsigned slot;
        int unsigned peak_slot;
        int unsigned peak_value;
        int unsigned running;
        logic [ihe_pkg::TOT_W-1:0] peak_count;
        t_bin_result r;
        if (bin_setting == 0)
            span_bins = 1;
        else if (bin_setting > MODEL_BINS)
            span_bins = MODEL_BINS;
        else
            span_bins = bin_setting;
        if (span_low <= span_high && px >= span_low && px <= span_high) begin
            span = span_high - span_low;
            slot = 0;
            if (span != 0) begin
                slot = ((int'(px) - int'(span_low)) * span_bins) / span;
                if (slot >= span_bins)
                    slot = span_bins - 1;
            end
            if (tally[slot] != ihe_pkg::TOT_MAX)
                tally[slot] = tally[slot] + 1'b1;
        end
        if (tail) begin
            peak_slot = 0;
            peak_count = tally[0];
            for (int k = 1; k < span_bins; k++) begin
                if (tally[k] > peak_count) begin
                    peak_count = tally[k];
                    peak_slot = k;
                end
            end
            if (span_high > span_low)
                peak_value = span_low + ((span_high - span_low) * peak_slot) / span_bins;
            else
                peak_value = span_low;
            running = 0;
            for (int k = 0; k < span_bins; k++) begin
                running = running + tally[k];
                if (running > ihe_pkg::TOT_MAX)
                    running = ihe_pkg::TOT_MAX;
                r.slot = ihe_pkg::IDX_W'(k);
                r.count = tally[k];
                r.running = ihe_pkg::TOT_W'(running);
                r.closing = (k == span_bins - 1);
                r.peak_value = r.closing ? ihe_pkg::PIX_W'(peak_value) : '0;
                r.peak_slot = r.closing ? ihe_pkg::IDX_W'(peak_slot) : '0;
                bins_due.push_back(r);
            end
            tally = '{default: '0};
        end
    endtask

    task automatic compare_field(input string label, input int unsigned exp_v,
                                 input int unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, exp_v, got_v);
            failed++;
        end
    endtask

    task automatic set_reg(input logic [ihe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ihe_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ihe_pkg::CFG_RANGE_LOW: span_low = data;
            ihe_pkg::CFG_RANGE_HIGH: span_high = data;
            ihe_pkg::CFG_BINS: bin_setting = data[ihe_pkg::BINS_CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic push_pixel(input logic [ihe_pkg::PIX_W-1:0] px, input logic tail);
        t_pixel p;
        p.value = px;
        p.closing = tail;
        pixel_feed.push_back(p);
        pushed++;
        if (pushed >= CALM_AFTER)
            calm = 1'b1;
    endtask

    task automatic wait_idle();
        while (accepted != pushed || bins_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [ihe_pkg::PIX_W-1:0] pick_pixel();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65 && span_low <= span_high)
            return ihe_pkg::PIX_W'($urandom_range(span_low, span_high));
        if (roll < 75)
            return $urandom_range(0, 1) ? span_low : span_high;
        if (roll < 85)
            return $urandom_range(0, 1) ? (span_low - 1'b1) : (span_high + 1'b1);
        return ihe_pkg::PIX_W'($urandom_range(0, 65535));
    endfunction

    function automatic int pick_pct();
        int unsigned roll;
        roll = $urandom_range(0, 3);
        if (roll == 0)
            return 0;
        return roll * 10;
    endfunction

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (feed_gap > 0) begin
                feed_gap = feed_gap - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
                feed_gap = $urandom_range(0, 5);
                i_s_axis_tvalid <= 1'b0;
            end else if (pixel_feed.size() != 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= pixel_feed[0].value;
                i_s_axis_tlast <= pixel_feed[0].closing;
                void'(pixel_feed.pop_front());
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // pixel transfers feed the model
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            tally_pixel(i_s_axis_tdata[ihe_pkg::PIX_W-1:0], i_s_axis_tlast);
            accepted++;
        end
    end

    // result back-pressure
    always @(posedge i_clk) begin
        if (sink_gap > 0) begin
            sink_gap = sink_gap - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            sink_gap = $urandom_range(0, 5);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (bins_due.size() == 0) begin
                $display("%0t: result transfer with none expected, expected none actual bin %0d",
                         $time, o_m_axis_tdata[5:0]);
                failed++;
            end else begin
                want = bins_due.pop_front();
                compare_field("bin_index", want.slot, o_m_axis_tdata[5:0]);
                compare_field("bin_total", want.count, o_m_axis_tdata[29:6]);
                compare_field("cumulative_total", want.running, o_m_axis_tdata[53:30]);
                compare_field("mode_value", want.peak_value, o_m_axis_tdata[69:54]);
                compare_field("mode_bin", want.peak_slot, o_m_axis_tdata[75:70]);
                compare_field("pad", 0, o_m_axis_tdata[ihe_pkg::OUT_DATA_W-1:76]);
                compare_field("final_res", want.closing, o_m_axis_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("image_histogram_engine regression: fail");
            $finish;
        end
    end

    initial begin
        int unsigned kind;
        int unsigned lo;
        int unsigned hi;
        int unsigned n;
        int unsigned roll;
        logic [ihe_pkg::CFG_DATA_W-1:0] bins_word;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset ranging: full span, 64 bins
        idle_pct = 20;
        stall_pct = 20;
        push_pixel(16'h0000, 1'b0);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'h5555, 1'b0);
        push_pixel(16'hAAAA, 1'b0);
        push_pixel(16'h0001, 1'b0);
        push_pixel(16'hFFFF, 1'b1);
        push_pixel(16'h0000, 1'b1);
        wait_idle();

        // empty span away from zero
        set_reg(ihe_pkg::CFG_RANGE_LOW, 16'd100);
        set_reg(ihe_pkg::CFG_RANGE_HIGH, 16'd100);
        set_reg(ihe_pkg::CFG_BINS, 16'd5);
        push_pixel(16'd100, 1'b0);
        push_pixel(16'd99, 1'b0);
        push_pixel(16'd101, 1'b0);
        push_pixel(16'd100, 1'b1);
        wait_idle();

        // inverted range, bin count above the maximum
        set_reg(ihe_pkg::CFG_RANGE_LOW, 16'd500);
        set_reg(ihe_pkg::CFG_RANGE_HIGH, 16'd200);
        set_reg(ihe_pkg::CFG_BINS, 16'hFFFF);
        push_pixel(16'd300, 1'b0);
        push_pixel(16'd500, 1'b0);
        push_pixel(16'd200, 1'b0);
        push_pixel(16'd0, 1'b1);
        wait_idle();

        // zero span at zero, bin count of zero, write to the spare index
        set_reg(ihe_pkg::CFG_RANGE_LOW, 16'd0);
        set_reg(ihe_pkg::CFG_RANGE_HIGH, 16'd0);
        set_reg(ihe_pkg::CFG_BINS, 16'hFF80);
        set_reg(CFG_SPARE, 16'hFFFF);
        push_pixel(16'd0, 1'b0);
        push_pixel(16'd0, 1'b0);
        push_pixel(16'd1, 1'b0);
        push_pixel(16'hFFFF, 1'b1);
        wait_idle();

        set_reg(ihe_pkg::CFG_RANGE_LOW, 16'hFFFF);
        set_reg(ihe_pkg::CFG_RANGE_HIGH, 16'hFFFF);
        set_reg(ihe_pkg::CFG_BINS, 16'd64);
        push_pixel(16'hFFFF, 1'b1);
        wait_idle();

        // two bins, top value folded into the last
        set_reg(ihe_pkg::CFG_RANGE_LOW, 16'd10);
        set_reg(ihe_pkg::CFG_RANGE_HIGH, 16'd20);
        set_reg(ihe_pkg::CFG_BINS, 16'd2);
        push_pixel(16'd10, 1'b0);
        push_pixel(16'd15, 1'b0);
        push_pixel(16'd20, 1'b1);
        wait_idle();

        while (pushed < ITEM_GOAL) begin
            kind = $urandom_range(0, 5);
            lo = $urandom_range(0, 65535);
            case (kind)
                0: begin
                    lo = 0;
                    hi = 65535;
                end
                1: hi = lo + $urandom_range(0, 300);
                2: hi = $urandom_range(0, 65535);
                3: hi = lo;
                4: hi = lo + $urandom_range(1, 10);
                default: begin
                    hi = $urandom_range(0, 65535);
                    if (hi < lo) begin
                        n = hi;
                        hi = lo;
                        lo = n;
                    end
                end
            endcase
            if (hi > 65535)
                hi = 65535;
            roll = $urandom_range(0, 9);
            if (roll == 0)
                bins_word = '0;
            else if (roll == 1)
                bins_word = ihe_pkg::CFG_DATA_W'($urandom_range(65, 127));
            else
                bins_word = ihe_pkg::CFG_DATA_W'($urandom_range(1, 64));
            bins_word = bins_word
                | ihe_pkg::CFG_DATA_W'($urandom_range(0, 511) << ihe_pkg::BINS_CFG_W);
            set_reg(ihe_pkg::CFG_RANGE_LOW, ihe_pkg::CFG_DATA_W'(lo));
            set_reg(ihe_pkg::CFG_RANGE_HIGH, ihe_pkg::CFG_DATA_W'(hi));
            set_reg(ihe_pkg::CFG_BINS, bins_word);
            if ($urandom_range(0, 3) == 0)
                set_reg(CFG_SPARE, ihe_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
            repeat ($urandom_range(1, 3)) begin
                idle_pct = pick_pct();
                stall_pct = pick_pct();
                n = $urandom_range(1, 20);
                for (int k = 0; k < n; k++)
                    push_pixel(pick_pixel(), k == n - 1);
            end
            wait_idle();
        end

        if (failed == 0)
            $display("image_histogram_engine regression: pass");
        else
            $display("image_histogram_engine regression: fail");
        $finish;
    end

endmodule
